// ===== rtl/lgp_pkg.sv =====
// Package for the linear gradient pixel block: register map, shared widths and types.
// No dependencies.
`default_nettype none

package lgp_pkg;

    localparam int COORD_W = 14;
    localparam int PIX_W   = 12;
    localparam int CW      = 32;   // projection values, exact for 14-bit points
    localparam int DVD_W   = 40;   // weighted channel sum, below 256 * span
    localparam int QBITS   = 8;
    localparam int NCH     = 3;
    localparam int ADDR_W  = 5;

    localparam logic [2:0] REG_START_X   = 3'd0;
    localparam logic [2:0] REG_START_Y   = 3'd1;
    localparam logic [2:0] REG_END_X     = 3'd2;
    localparam logic [2:0] REG_END_Y     = 3'd3;
    localparam logic [2:0] REG_START_RGB = 3'd4;
    localparam logic [2:0] REG_END_RGB   = 3'd5;

    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_MID
    } sel_t;

    // values derived from the registers; the user keeps them constant while pixels flow, the block does not enforce it
    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c1;
        logic signed [CW-1:0] c2;
        logic [CW-1:0]        span;
        logic [23:0]          start_rgb;
        logic [23:0]          end_rgb;
    } cfg_t;

    typedef struct packed {
        sel_t                            sel;
        logic [NCH-1:0][DVD_W-1:0]       dvd;
    } work_t;

endpackage

`default_nettype wire

// ===== rtl/lgp_if.sv =====
// Handshake channels for pixel positions and pixel colors.
// Depends on nothing.
`default_nettype none

interface pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] column;
    logic [11:0] row;
    modport source (output valid, output column, output row, input ready);
    modport sink (input valid, input column, input row, output ready);
endinterface

interface rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, output blue, output green, output red, input ready);
    modport sink (input valid, input blue, input green, input red, output ready);
endinterface

`default_nettype wire

// ===== rtl/linear_gradient_pixel.sv =====
// Two-point linear gradient: pixel position in, 24-bit color out.
// One word per clock sustained while the color output is ready.
// Six projection stages feed eight divider stages, each producing one quotient bit.
// Every stage holds its word under backpressure and refills as soon as it moves on.
// rst_n (async, active low) empties the pipeline and loads register defaults.
// Depends on lgp_pkg, pix_if, rgb_if, lgp_cfg, lgp_proj, lgp_div.
`default_nettype none

module linear_gradient_pixel #(
    parameter int MAX_SIDE = 4096
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [lgp_pkg::ADDR_W-1:0]  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    pix_if.sink                        pix,
    rgb_if.source                      color
);

    lgp_pkg::cfg_t  cfg;
    lgp_pkg::work_t work;
    logic           work_valid;
    logic           work_ready;

    lgp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lgp_proj #(
        .MAX_SIDE (MAX_SIDE)
    ) u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .column    (pix.column),
        .row       (pix.row),
        .out_valid (work_valid),
        .out_ready (work_ready),
        .out_work  (work)
    );

    lgp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (work_valid),
        .in_ready  (work_ready),
        .in_work   (work),
        .out_valid (color.valid),
        .out_ready (color.ready),
        .blue      (color.blue),
        .green     (color.green),
        .red       (color.red)
    );

endmodule

`default_nettype wire

// ===== rtl/lgp_cfg.sv =====
// APB register file and the derived gradient terms (direction, end projections, span).
// Depends on lgp_pkg.
`default_nettype none

module lgp_cfg (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lgp_pkg::ADDR_W-1:0]    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lgp_pkg::cfg_t                cfg
);

    logic signed [13:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [23:0]        srgb_reg, ergb_reg;
    logic [2:0]         idx;
    logic               wr;

    logic signed [31:0] a_reg, b_reg, sx_w, sy_w, ex_w, ey_w;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, p4_reg, c1_reg, c2_reg;
    logic [31:0]        span_reg;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg   <= '0;
            sy_reg   <= '0;
            ex_reg   <= '0;
            ey_reg   <= '0;
            srgb_reg <= '0;
            ergb_reg <= 24'hFFFFFF;
        end
        else if (wr)
        begin
            unique case (idx)
                lgp_pkg::REG_START_X:   sx_reg   <= pwdata[13:0];
                lgp_pkg::REG_START_Y:   sy_reg   <= pwdata[13:0];
                lgp_pkg::REG_END_X:     ex_reg   <= pwdata[13:0];
                lgp_pkg::REG_END_Y:     ey_reg   <= pwdata[13:0];
                lgp_pkg::REG_START_RGB: srgb_reg <= pwdata[23:0];
                lgp_pkg::REG_END_RGB:   ergb_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lgp_pkg::REG_START_X:   prdata = 32'(sx_reg);
            lgp_pkg::REG_START_Y:   prdata = 32'(sy_reg);
            lgp_pkg::REG_END_X:     prdata = 32'(ex_reg);
            lgp_pkg::REG_END_Y:     prdata = 32'(ey_reg);
            lgp_pkg::REG_START_RGB: prdata = {8'd0, srgb_reg};
            lgp_pkg::REG_END_RGB:   prdata = {8'd0, ergb_reg};
            default:                prdata = '0;
        endcase
    end

    assign sx_w = 32'(sx_reg);
    assign sy_w = 32'(sy_reg);
    assign ex_w = 32'(ex_reg);
    assign ey_w = 32'(ey_reg);

    // registered derived terms (a and b, products, end projections, span); pixels are not held back until they settle
    always_ff @(posedge clk)
    begin
        a_reg    <= ex_w - sx_w;
        b_reg    <= ey_w - sy_w;
        p1_reg   <= a_reg * sx_w;
        p2_reg   <= b_reg * sy_w;
        p3_reg   <= a_reg * ex_w;
        p4_reg   <= b_reg * ey_w;
        c1_reg   <= p1_reg + p2_reg;
        c2_reg   <= p3_reg + p4_reg;
        span_reg <= c2_reg - c1_reg;
    end

    assign cfg.a         = a_reg;
    assign cfg.b         = b_reg;
    assign cfg.c1        = c1_reg;
    assign cfg.c2        = c2_reg;
    assign cfg.span      = span_reg;
    assign cfg.start_rgb = srgb_reg;
    assign cfg.end_rgb   = ergb_reg;

endmodule

`default_nettype wire

// ===== rtl/lgp_proj.sv =====
// Projection pipeline: clamp, project onto the gradient direction, classify,
// and form the weighted channel sums. Depends on lgp_pkg.
`default_nettype none

module lgp_proj #(
    parameter int MAX_SIDE = 4096
) (
    input  wire                clk,
    input  wire                rst_n,
    input  lgp_pkg::cfg_t      cfg,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [11:0]         column,
    input  wire [11:0]         row,
    output logic               out_valid,
    input  wire                out_ready,
    output lgp_pkg::work_t     out_work
);

    localparam int LIM = (MAX_SIDE - 1 > 4095) ? 4095 : MAX_SIDE - 1;
    localparam int NS  = 6;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [11:0]        col_reg, row_reg;
    logic signed [31:0] pa_reg, pb_reg, c_reg;
    logic [31:0]        wa_reg, wb_reg;
    lgp_pkg::sel_t      sel4_reg, sel5_reg;
    logic [2:0][39:0]   ps_reg, pe_reg;
    lgp_pkg::work_t     w_reg;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            col_reg <= (column > 12'(LIM)) ? 12'(LIM) : column;
            row_reg <= (row > 12'(LIM)) ? 12'(LIM) : row;
        end
        if (en[1])
        begin
            pa_reg <= cfg.a * $signed({20'd0, col_reg});
            pb_reg <= cfg.b * $signed({20'd0, row_reg});
        end
        if (en[2])
        begin
            c_reg <= pa_reg + pb_reg;
        end
        if (en[3])
        begin
            wa_reg <= cfg.c2 - c_reg;
            wb_reg <= c_reg - cfg.c1;
            if (c_reg <= cfg.c1)
            begin
                sel4_reg <= lgp_pkg::SEL_START;
            end
            else if (c_reg >= cfg.c2)
            begin
                sel4_reg <= lgp_pkg::SEL_END;
            end
            else
            begin
                sel4_reg <= lgp_pkg::SEL_MID;
            end
        end
        if (en[4])
        begin
            sel5_reg <= sel4_reg;
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[k] <= 40'(cfg.start_rgb[8*k +: 8]) * 40'(wa_reg);
                pe_reg[k] <= 40'(cfg.end_rgb[8*k +: 8]) * 40'(wb_reg);
            end
        end
        if (en[5])
        begin
            w_reg.sel <= sel5_reg;
            for (int k = 0; k < 3; k++)
            begin
                w_reg.dvd[k] <= ps_reg[k] + pe_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_work  = w_reg;

endmodule

`default_nettype wire

// ===== rtl/lgp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for all three channels,
// plus the final color select. Depends on lgp_pkg.
`default_nettype none

module lgp_div (
    input  wire                clk,
    input  wire                rst_n,
    input  lgp_pkg::cfg_t      cfg,
    input  wire                in_valid,
    output logic               in_ready,
    input  lgp_pkg::work_t     in_work,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [7:0]         blue,
    output logic [7:0]         green,
    output logic [7:0]         red
);

    localparam int NS = lgp_pkg::QBITS;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;
    lgp_pkg::work_t w_reg [NS];
    logic [2:0][7:0] q_reg [NS];
    logic [2:0][7:0] res;

    always_comb
    begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        lgp_pkg::work_t  w_in, w_next;
        logic [2:0][7:0] q_in, q_next;
        logic [39:0]     dsh;

        if (j == 0)
        begin : g_first
            assign w_in = in_work;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign w_in = w_reg[j-1];
            assign q_in = q_reg[j-1];
        end

        // divisor aligned to quotient bit NS-1-j
        assign dsh = 40'(cfg.span) << (NS - 1 - j);

        always_comb
        begin
            w_next = w_in;
            q_next = q_in;
            for (int k = 0; k < 3; k++)
            begin
                if (w_in.dvd[k] >= dsh)
                begin
                    w_next.dvd[k]        = w_in.dvd[k] - dsh;
                    q_next[k][NS-1-j]    = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                w_reg[j] <= w_next;
                q_reg[j] <= q_next;
            end
        end
    end

    always_comb
    begin
        unique case (w_reg[NS-1].sel)
            lgp_pkg::SEL_START: res = cfg.start_rgb;
            lgp_pkg::SEL_END:   res = cfg.end_rgb;
            default:            res = q_reg[NS-1];
        endcase
    end

    assign out_valid = v_reg[NS-1];
    assign blue      = res[0];
    assign green     = res[1];
    assign red       = res[2];

endmodule

`default_nettype wire
